// ===== hdl/tmcs_pkg.sv =====
// Shared types and constants for the tile map collision scan block.
// No dependencies; imported by every module of the block.
package tmcs_pkg;

    typedef enum logic [1:0] {
        OP_MAP_WR   = 2'd0,
        OP_ATTR_WR  = 2'd1,
        OP_SCAN_COL = 2'd2,
        OP_SCAN_ROW = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1,
        CFG_OFF_ATTR   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDX,
        ST_MAP,
        ST_ATTR,
        ST_CHK
    } t_state;

    typedef struct packed {
        logic map_we;
        logic map_re;
        logic attr_we;
        logic attr_re;
    } t_store_ctl;

    localparam logic [7:0] RST_MAP_WIDTH  = 8'd32;
    localparam logic [7:0] RST_MAP_HEIGHT = 8'd32;
    localparam logic [7:0] RST_OFF_ATTR   = 8'd255;

endpackage

// ===== hdl/tmcs_store.sv =====
// Tile map and attribute table memories with registered read data.
// Depends on tmcs_pkg for the access control struct.
module tmcs_store import tmcs_pkg::*; #(
    parameter int MAP_CELLS  = 65536,
    parameter int TILE_KINDS = 256,
    parameter int MAP_AW     = $clog2(MAP_CELLS),
    parameter int TILE_AW    = $clog2(TILE_KINDS)
) (
    input  logic               i_clk,
    input  t_store_ctl         i_ctl,
    input  logic [MAP_AW-1:0]  i_map_waddr,
    input  logic [MAP_AW-1:0]  i_map_raddr,
    input  logic [TILE_AW-1:0] i_attr_waddr,
    input  logic [TILE_AW-1:0] i_attr_raddr,
    input  logic [7:0]         i_wdata,
    output logic [7:0]         o_tile,
    output logic [7:0]         o_attr
);

    logic [7:0] r_map_mem  [MAP_CELLS];
    logic [7:0] r_attr_mem [TILE_KINDS];
    logic [7:0] r_tile;
    logic [7:0] r_attr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.map_we) begin
            r_map_mem[i_map_waddr] <= i_wdata;
        end
        if (i_ctl.map_re) begin
            r_tile <= r_map_mem[i_map_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.attr_we) begin
            r_attr_mem[i_attr_waddr] <= i_wdata;
        end
        if (i_ctl.attr_re) begin
            r_attr <= r_attr_mem[i_attr_raddr];
        end
    end

    assign o_tile = r_tile;
    assign o_attr = r_attr;

endmodule

// ===== hdl/tile_map_range_collision_scan.sv =====
// Tile map collision line scan: sequencer, shared index unit and output register.
// Depends on tmcs_pkg and tmcs_store.
//
// Usage:
// - Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) sets map
//   width (0), map height (1) and the off-map attribute (2); it is always ready and
//   must only be written while the block is idle.
// - Slave stream: tuser carries the operation, tdata the item fields. Map and table
//   writes return an all-zero result transaction.
// - A scan visits one cell per step; each step runs index multiply-add, map read,
//   attribute table read and test in turn. A scan that starts off the map answers
//   without stepping; otherwise it visits up to 255 cells. Each step uses the shared
//   y * width + x unit and the two memory read ports.
// - One item is in work at a time; the slave side is not ready while a scan runs.
// - The result sits in an output register. While the master side stalls, the block
//   holds the result and accepts no new transaction.
// - Reset returns the sequencer to idle, drops any pending result and loads the
//   configuration defaults (32, 32, 255). Map and table contents are undefined
//   until written.
module tile_map_range_collision_scan import tmcs_pkg::*; #(
    parameter int MAP_CELLS  = 65536,
    parameter int TILE_KINDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // op[1:0]
    input  logic [1:0]  i_s_tuser,
    // test_mask[7:0], fixed_coord[15:8], start_coord[23:16], stop_coord[31:24],
    // map_addr[47:32], tile_id[55:48], write_data[63:56]
    input  logic [63:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // attribute[7:0], hit_x[15:8], hit_y[23:16]
    output logic [23:0] o_m_tdata
);

    localparam int MAP_AW  = $clog2(MAP_CELLS);
    localparam int TILE_AW = $clog2(TILE_KINDS);
    localparam logic [16:0] MAP_LIM  = 17'(MAP_CELLS);
    localparam logic [8:0]  TILE_LIM = 9'(TILE_KINDS);

    t_state      r_state, n_state;
    logic [7:0]  r_width, r_height, r_off_attr;
    logic [7:0]  r_x, n_x, r_y, n_y, r_pos, n_pos, r_stop, n_stop, r_mask, n_mask;
    logic        r_col, n_col, r_up, n_up;
    logic [16:0] r_idx, n_idx;
    logic        r_map_ok, n_map_ok, r_tile_ok, n_tile_ok;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_res_attr, n_res_attr, r_res_x, n_res_x, r_res_y, n_res_y;

    t_store_ctl  store_ctl;
    logic [7:0]  map_q, attr_q;
    logic [7:0]  in_mask, in_fixed, in_start, in_stop, in_tile_id, in_wdata;
    logic [15:0] in_map_addr;
    t_op         in_op;
    logic        s_acc, scan_col;
    logic [7:0]  s_x, s_y, off_ans, step_pos, limit, tile_sel, cell_attr;
    logic [15:0] prod;
    logic [16:0] idx_sum;
    logic        idx_ok, tile_ok;

    assign in_op       = t_op'(i_s_tuser);
    assign in_mask     = i_s_tdata[7:0];
    assign in_fixed    = i_s_tdata[15:8];
    assign in_start    = i_s_tdata[23:16];
    assign in_stop     = i_s_tdata[31:24];
    assign in_map_addr = i_s_tdata[47:32];
    assign in_tile_id  = i_s_tdata[55:48];
    assign in_wdata    = i_s_tdata[63:56];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_res_y, r_res_x, r_res_attr};

    assign scan_col = (in_op == OP_SCAN_COL);
    assign s_x      = scan_col ? in_fixed : in_start;
    assign s_y      = scan_col ? in_start : in_fixed;

    assign prod      = {8'd0, r_y} * {8'd0, r_width};
    assign idx_sum   = {1'b0, prod} + {9'd0, r_x};
    assign idx_ok    = r_idx < MAP_LIM;
    assign tile_sel  = r_map_ok ? map_q : 8'd0;
    assign tile_ok   = {1'b0, tile_sel} < TILE_LIM;
    assign cell_attr = r_tile_ok ? attr_q : 8'd0;
    assign step_pos  = r_up ? (r_pos + 8'd1) : (r_pos - 8'd1);
    assign limit     = r_col ? r_height : r_width;

    always_comb begin
        off_ans = '0;
        if (r_state == ST_IDLE) begin
            off_ans = ((r_off_attr & in_mask) != 8'd0) ? r_off_attr : 8'd0;
        end else begin
            off_ans = ((r_off_attr & r_mask) != 8'd0) ? r_off_attr : 8'd0;
        end
    end

    tmcs_store #(
        .MAP_CELLS  (MAP_CELLS),
        .TILE_KINDS (TILE_KINDS),
        .MAP_AW     (MAP_AW),
        .TILE_AW    (TILE_AW)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (store_ctl),
        .i_map_waddr  (in_map_addr[MAP_AW-1:0]),
        .i_map_raddr  (r_idx[MAP_AW-1:0]),
        .i_attr_waddr (in_tile_id[TILE_AW-1:0]),
        .i_attr_raddr (tile_sel[TILE_AW-1:0]),
        .i_wdata      (in_wdata),
        .o_tile       (map_q),
        .o_attr       (attr_q)
    );

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_pos       = r_pos;
        n_stop      = r_stop;
        n_mask      = r_mask;
        n_col       = r_col;
        n_up        = r_up;
        n_idx       = r_idx;
        n_map_ok    = r_map_ok;
        n_tile_ok   = r_tile_ok;
        n_out_valid = r_out_valid && !i_m_tready;
        n_res_attr  = r_res_attr;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        store_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (in_op == OP_MAP_WR || in_op == OP_ATTR_WR) begin
                        store_ctl.map_we  = (in_op == OP_MAP_WR) &&
                                            ({1'b0, in_map_addr} < MAP_LIM);
                        store_ctl.attr_we = (in_op == OP_ATTR_WR) &&
                                            ({1'b0, in_tile_id} < TILE_LIM);
                        n_out_valid = 1'b1;
                        n_res_attr  = 8'd0;
                        n_res_x     = 8'd0;
                        n_res_y     = 8'd0;
                    end else if (s_x >= r_width || s_y >= r_height) begin
                        n_out_valid = 1'b1;
                        n_res_attr  = off_ans;
                        n_res_x     = s_x;
                        n_res_y     = s_y;
                    end else begin
                        n_x     = s_x;
                        n_y     = s_y;
                        n_pos   = in_start;
                        n_stop  = in_stop;
                        n_mask  = in_mask;
                        n_col   = scan_col;
                        n_up    = in_start < in_stop;
                        n_state = ST_IDX;
                    end
                end
            end
            ST_IDX: begin
                n_idx   = idx_sum;
                n_state = ST_MAP;
            end
            ST_MAP: begin
                store_ctl.map_re = idx_ok;
                n_map_ok         = idx_ok;
                n_state          = ST_ATTR;
            end
            ST_ATTR: begin
                store_ctl.attr_re = tile_ok;
                n_tile_ok         = tile_ok;
                n_state           = ST_CHK;
            end
            ST_CHK: begin
                if ((cell_attr & r_mask) != 8'd0) begin
                    n_out_valid = 1'b1;
                    n_res_attr  = cell_attr;
                    n_res_x     = r_x;
                    n_res_y     = r_y;
                    n_state     = ST_IDLE;
                end else if (r_pos == r_stop) begin
                    n_out_valid = 1'b1;
                    n_res_attr  = 8'd0;
                    n_res_x     = r_x;
                    n_res_y     = r_y;
                    n_state     = ST_IDLE;
                end else begin
                    n_pos = step_pos;
                    if (r_col) begin
                        n_y = step_pos;
                    end else begin
                        n_x = step_pos;
                    end
                    if (step_pos >= limit) begin
                        n_out_valid = 1'b1;
                        n_res_attr  = off_ans;
                        n_res_x     = r_col ? r_x : step_pos;
                        n_res_y     = r_col ? step_pos : r_y;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_IDX;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= RST_MAP_WIDTH;
            r_height    <= RST_MAP_HEIGHT;
            r_off_attr  <= RST_OFF_ATTR;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MAP_WIDTH:  r_width    <= i_cfg_data;
                    CFG_MAP_HEIGHT: r_height   <= i_cfg_data;
                    CFG_OFF_ATTR:   r_off_attr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_pos      <= n_pos;
        r_stop     <= n_stop;
        r_mask     <= n_mask;
        r_col      <= n_col;
        r_up       <= n_up;
        r_idx      <= n_idx;
        r_map_ok   <= n_map_ok;
        r_tile_ok  <= n_tile_ok;
        r_res_attr <= n_res_attr;
        r_res_x    <= n_res_x;
        r_res_y    <= n_res_y;
    end

endmodule

// ===== hdl/tmcs_checker.sv =====
// Port-level checks for the tile map collision scan block, bound to its top level.
// Depends on tmcs_pkg for operation codes.
module tmcs_checker import tmcs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [7:0]  i_cfg_data,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic [63:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while result stalled");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready &&
        (i_s_tuser == OP_MAP_WR || i_s_tuser == OP_ATTR_WR)
        |=> o_m_tvalid && (o_m_tdata == 24'd0))
        else $error("write transaction did not return a zero result");

    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready &&
        (i_s_tuser == OP_SCAN_COL || i_s_tuser == OP_SCAN_ROW)
        |=> o_m_tvalid || !o_s_tready)
        else $error("scan neither answered nor held the input side");

endmodule

bind tile_map_range_collision_scan tmcs_checker u_tmcs_checker (.*);

// ===== test/tile_map_range_collision_scan_tb.sv =====
// Self-checking testbench for tile_map_range_collision_scan: map/table loads and line scans.
// Drives the stream port with random bursts and output stalls, and the configuration port between runs.
// Depends on tmcs_pkg and the block's RTL.
module tile_map_range_collision_scan_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcs_pkg::*;

    localparam int MAP_CELLS   = 65536;
    localparam int TILE_KINDS  = 256;
    localparam int CYCLE_LIMIT = 5_000_000;

    typedef struct packed {
        logic [7:0]  write_data;
        logic [7:0]  tile_id;
        logic [15:0] map_addr;
        logic [7:0]  stop_coord;
        logic [7:0]  start_coord;
        logic [7:0]  fixed_coord;
        logic [7:0]  test_mask;
    } t_item_data;

    typedef struct packed {
        logic [7:0] hit_y;
        logic [7:0] hit_x;
        logic [7:0] attribute;
    } t_hit;

    class scan_scoreboard;
        bit [7:0] cells [MAP_CELLS];
        bit       cell_set [MAP_CELLS];
        bit [7:0] attrs [TILE_KINDS];
        bit       attr_set [TILE_KINDS];
        bit [7:0] known_ids [$];
        bit [7:0] width    = RST_MAP_WIDTH;
        bit [7:0] height   = RST_MAP_HEIGHT;
        bit [7:0] off_attr = RST_OFF_ATTR;
        t_hit     pending_hits [$];
        int       errors;

        function void set_reg(t_cfg_idx idx, bit [7:0] value);
            case (idx)
                CFG_MAP_WIDTH:  width = value;
                CFG_MAP_HEIGHT: height = value;
                CFG_OFF_ATTR:   off_attr = value;
                default: ;
            endcase
        endfunction

        function bit [7:0] off_answer(bit [7:0] mask);
            return ((off_attr & mask) != 0) ? off_attr : 8'h00;
        endfunction

        // Walk one row or column; flag any read of a cell or table entry never written.
        function t_hit trace_line(t_op op, t_item_data d, output bit unsafe);
            t_hit     h;
            bit       column;
            bit [7:0] pos, limit, id, a;
            int       n, idx;
            h = '0;
            unsafe = 1'b0;
            if (op == OP_MAP_WR || op == OP_ATTR_WR) return h;
            column = (op == OP_SCAN_COL);
            pos = d.start_coord;
            limit = column ? height : width;
            h.hit_x = column ? d.fixed_coord : d.start_coord;
            h.hit_y = column ? d.start_coord : d.fixed_coord;
            if (h.hit_x >= width || h.hit_y >= height) begin
                h.attribute = off_answer(d.test_mask);
                return h;
            end
            for (n = 0; n < 256; n++) begin
                idx = int'(h.hit_y) * int'(width) + int'(h.hit_x);
                id = cells[idx];
                if (!cell_set[idx] || !attr_set[id]) unsafe = 1'b1;
                a = attrs[id];
                if ((a & d.test_mask) != 0) begin
                    h.attribute = a;
                    break;
                end
                if (pos == d.stop_coord) break;
                pos = (d.start_coord < d.stop_coord) ? pos + 8'd1 : pos - 8'd1;
                if (column) h.hit_y = pos;
                else h.hit_x = pos;
                if (pos >= limit) begin
                    h.attribute = off_answer(d.test_mask);
                    break;
                end
            end
            return h;
        endfunction

        function void note_item(t_op op, t_item_data d);
            bit unsafe;
            case (op)
                OP_MAP_WR: begin
                    if (int'(d.map_addr) < MAP_CELLS) begin
                        cells[d.map_addr] = d.write_data;
                        cell_set[d.map_addr] = 1'b1;
                    end
                end
                OP_ATTR_WR: begin
                    if (int'(d.tile_id) < TILE_KINDS) begin
                        if (!attr_set[d.tile_id]) known_ids.push_back(d.tile_id);
                        attrs[d.tile_id] = d.write_data;
                        attr_set[d.tile_id] = 1'b1;
                    end
                end
                default: ;
            endcase
            pending_hits.push_back(trace_line(op, d, unsafe));
        endfunction

        function void check_hit(t_hit got);
            t_hit want;
            if (pending_hits.size() == 0) begin
                $error("unexpected result transaction %h", got);
                errors++;
                return;
            end
            want = pending_hits.pop_front();
            if (got.attribute !== want.attribute) begin
                $error("attribute: expected %0h, got %0h", want.attribute, got.attribute);
                errors++;
            end
            if (got.hit_x !== want.hit_x) begin
                $error("hit_x: expected %0h, got %0h", want.hit_x, got.hit_x);
                errors++;
            end
            if (got.hit_y !== want.hit_y) begin
                $error("hit_y: expected %0h, got %0h", want.hit_y, got.hit_y);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_MAP_WIDTH;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [1:0]  i_s_tuser = OP_MAP_WR;
    logic [63:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;

    scan_scoreboard board;
    int          burst_left;
    int          rx_mode;
    int          stall_left;
    int unsigned rx_cycle;
    int unsigned cycle_count;

    tile_map_range_collision_scan #(
        .MAP_CELLS (MAP_CELLS),
        .TILE_KINDS(TILE_KINDS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tile_map_range_collision_scan_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_hit(t_hit'(o_m_tdata));
        rx_cycle++;
        if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 40);
                end
            end
        endcase
    end

    function automatic t_item_data random_fields();
        return t_item_data'({$urandom(), $urandom()});
    endfunction

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2, 3, 4, 5: return 8'h01 << $urandom_range(0, 7);
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_op op, input t_item_data d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_item(op, d);
        burst_left--;
    endtask

    task automatic wr_map(input logic [15:0] addr, input logic [7:0] tile);
        t_item_data d;
        d = random_fields();
        d.map_addr = addr;
        d.write_data = tile;
        send_item(OP_MAP_WR, d);
    endtask

    task automatic wr_attr(input logic [7:0] tile, input logic [7:0] attr);
        t_item_data d;
        d = random_fields();
        d.tile_id = tile;
        d.write_data = attr;
        send_item(OP_ATTR_WR, d);
    endtask

    task automatic scan_line(input t_op op, input logic [7:0] mask, input logic [7:0] fixed,
                             input logic [7:0] start, input logic [7:0] stop);
        t_item_data d;
        d = random_fields();
        d.test_mask = mask;
        d.fixed_coord = fixed;
        d.start_coord = start;
        d.stop_coord = stop;
        send_item(op, d);
    endtask

    // Load every cell along the path with a known tile, then scan it.
    task automatic line_sequence(output int count);
        t_op        op;
        logic [7:0] limit, other, fixed, start, stop, pos, x, y;
        int         len, idx, n;
        bit         need;
        op = $urandom_range(0, 1) ? OP_SCAN_COL : OP_SCAN_ROW;
        limit = (op == OP_SCAN_COL) ? board.height : board.width;
        other = (op == OP_SCAN_COL) ? board.width : board.height;
        fixed = (other == 0 || $urandom_range(0, 9) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, other - 1));
        start = (limit == 0 || $urandom_range(0, 9) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, limit - 1));
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        if ($urandom_range(0, 1)) stop = (int'(start) + len > 255) ? 8'd255 : 8'(int'(start) + len);
        else stop = (int'(start) < len) ? 8'd0 : 8'(int'(start) - len);
        count = 0;
        pos = start;
        for (n = 0; n < 256 && fixed < other && pos < limit; n++) begin
            x = (op == OP_SCAN_COL) ? fixed : pos;
            y = (op == OP_SCAN_COL) ? pos : fixed;
            idx = int'(y) * int'(board.width) + int'(x);
            need = !board.cell_set[idx] || !board.attr_set[board.cells[idx]]
                   || $urandom_range(0, 3) == 0;
            if (need) begin
                wr_map(16'(idx), board.known_ids[$urandom_range(0, board.known_ids.size() - 1)]);
                count++;
            end
            if (pos == stop) break;
            pos = (start < stop) ? pos + 8'd1 : pos - 8'd1;
        end
        scan_line(op, pick_mask(), fixed, start, stop);
        count++;
    endtask

    task automatic run_random(input int quota);
        int         sent, made;
        t_op        op;
        t_item_data d;
        bit         unsafe;
        sent = 0;
        while (sent < quota) begin
            case ($urandom_range(0, 9))
                0: begin
                    wr_attr(8'($urandom), ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
                    sent++;
                end
                1: begin
                    wr_map(16'($urandom), 8'($urandom));
                    sent++;
                end
                2: begin
                    op = $urandom_range(0, 1) ? OP_SCAN_COL : OP_SCAN_ROW;
                    d = random_fields();
                    d.test_mask = pick_mask();
                    void'(board.trace_line(op, d, unsafe));
                    if (!unsafe) begin
                        send_item(op, d);
                        sent++;
                    end
                end
                default: begin
                    line_sequence(made);
                    sent += made;
                end
            endcase
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending_hits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, value);
    endtask

    task automatic apply_geometry(input logic [7:0] w, input logic [7:0] h,
                                  input logic [7:0] off);
        drain();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_OFF_ATTR, off);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        wr_attr(8'd0, 8'h00);
        wr_attr(8'd255, 8'h80);
        wr_attr(8'd1, 8'h01);
        wr_attr(8'd2, 8'hFF);
        wr_map(16'd0, 8'd1);
        wr_map(16'd1, 8'd0);
        wr_map(16'd2, 8'd2);
        wr_map(16'd30, 8'd0);
        wr_map(16'd31, 8'd255);
        wr_map(16'd32, 8'd0);
        wr_map(16'd1023, 8'd2);
        wr_map(16'hFFFF, 8'hFF);
        scan_line(OP_SCAN_ROW, 8'h02, 8'd0, 8'd0, 8'd2);
        scan_line(OP_SCAN_ROW, 8'h00, 8'd0, 8'd2, 8'd0);
        // run off the right edge, with and without the off-map attribute meeting the mask
        scan_line(OP_SCAN_ROW, 8'h01, 8'd0, 8'd30, 8'd40);
        scan_line(OP_SCAN_ROW, 8'h00, 8'd0, 8'd30, 8'd40);
        scan_line(OP_SCAN_COL, 8'hFF, 8'd40, 8'd0, 8'd5);
        scan_line(OP_SCAN_COL, 8'h01, 8'd0, 8'd0, 8'd1);
        scan_line(OP_SCAN_COL, 8'h02, 8'd0, 8'd1, 8'd0);
        scan_line(OP_SCAN_COL, 8'h80, 8'd31, 8'd31, 8'd31);
        scan_line(OP_SCAN_COL, 8'h80, 8'd31, 8'd0, 8'd0);
        scan_line(OP_SCAN_ROW, 8'hFF, 8'd255, 8'd255, 8'd0);

        run_random(85);
        apply_geometry(8'd16, 8'd12, 8'h81);
        run_random(85);
        apply_geometry(8'd255, 8'd255, 8'h00);
        run_random(85);
        apply_geometry(8'd1, 8'd255, 8'hFF);
        run_random(85);
        apply_geometry(8'd0, 8'd9, 8'($urandom));
        run_random(40);
        apply_geometry(8'd255, 8'd0, 8'h3C);
        run_random(40);
        apply_geometry(8'($urandom_range(2, 40)), 8'($urandom_range(2, 40)), 8'($urandom));
        run_random(120);

        drain();
        repeat (1100) @(posedge i_clk);
        if (board.errors == 0 && board.pending_hits.size() == 0) begin
            $display("tile_map_range_collision_scan_tb: PASS");
        end else begin
            $display("tile_map_range_collision_scan_tb: FAIL");
        end
        $finish;
    end

endmodule
